@@ hdl/hdec_pkg.sv @@
// package for the half-duplex echo check node with receive ring
// types, codes and defaults shared by all modules; no dependencies
package hdec_pkg;

  localparam int RING_DEPTH_DEF = 64;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  // item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_RX    = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NEW      = 3'd2;
  localparam logic [2:0] ST_NO_ECHO  = 3'd3;
  localparam logic [2:0] ST_BAD_ECHO = 3'd4;
  localparam logic [2:0] ST_FULL_ECH = 3'd5;
  localparam logic [2:0] ST_EXTRA    = 3'd6;
  localparam logic [2:0] ST_BUSY     = 3'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_RETRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_TICKS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_RETRY  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } in_word_t;

  typedef struct packed {
    logic       status_valid;
    logic [2:0] status;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       read_valid;
    logic [7:0] read_data;
    logic [6:0] fill_count;
    logic       ring_full;
    logic       rx_refused;
  } out_word_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_QUIET = 3'b010,
    PH_ECHO  = 3'b100
  } phase_t;

endpackage

@@ hdl/halfduplex_echo_check_rx_fifo.sv @@
// top level of the half-duplex echo check node with receive ring
// depends on hdec_pkg, hdec_front, hdec_back
//
// Input words carry a kind (tick, received line byte, host write, host read)
// and a data byte; every accepted input word yields exactly one result word
// with status, transmit drive, popped byte and ring fill state.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user is to
// write it only while idle, as the block does not enforce this. A two-word
// skid queue takes input words; the back end handles one word a cycle
// unless the result stalls or a ring read is pending. Words pass a queue
// slot and the registered output word; a host read that pops a byte also
// waits on the registered ring memory read, which holds the back end.
// Reset (rst_n low, synchronous) empties the ring, returns to idle and loads
// the register defaults. A stalled result holds its word; the queue then
// fills and in_stall rises after two further words.
module halfduplex_echo_check_rx_fifo #(
  parameter int RING_DEPTH = hdec_pkg::RING_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  hdec_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output hdec_pkg::out_word_t            out_word,
  input  logic                           cfg_we,
  input  logic [hdec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hdec_pkg::CFG_W-1:0]     cfg_data
);
  import hdec_pkg::*;

  in_word_t q_word;
  logic     q_valid, q_take;

  // front queue
  hdec_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_word,
    .q_valid, .q_take, .q_word
  );

  // back end
  hdec_back #(.RING_DEPTH(RING_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_word,
    .cfg_we, .cfg_index, .cfg_data,
    .out_valid, .out_stall, .out_word
  );
endmodule

@@ hdl/hdec_front.sv @@
// front end: input skid queue of two words between input channel and back end
// depends on hdec_pkg
module hdec_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hdec_pkg::in_word_t in_word,
  output logic              q_valid,
  input  logic              q_take,
  output hdec_pkg::in_word_t q_word
);
  import hdec_pkg::*;

  in_word_t   slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_word   = slot_r[rd_r];

  // occupancy count
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= in_word;
  end
endmodule

@@ hdl/hdec_back.sv @@
// back end: ring, phase sequencer, timers and registered output word
// depends on hdec_pkg
module hdec_back #(
  parameter int RING_DEPTH = hdec_pkg::RING_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_take,
  input  hdec_pkg::in_word_t         q_word,
  input  logic                       cfg_we,
  input  logic [hdec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hdec_pkg::CFG_W-1:0] cfg_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output hdec_pkg::out_word_t        out_word
);
  import hdec_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

  logic [7:0]    mem [RING_DEPTH];
  logic [7:0]    rd_data_r;
  logic          rd_pend_r;

  logic [CFG_W-1:0] echo_ticks_r, echo_retries_r, quiet_ticks_r, quiet_retries_r;
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic          full_r, full_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  phase_t        phase_r, phase_nxt;
  logic [15:0]   tick_r, tick_nxt;
  logic [16:0]   retry_r, retry_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic          mism_r, mism_nxt, unseen_r, unseen_nxt;
  logic          ovalid_r;
  out_word_t     ow_r, ow_nxt;
  logic          push, pop;
  logic [15:0]   tick_inc;
  logic [16:0]   retry_inc;
  logic [15:0]   per;
  logic          echo_zero;

  // one item per cycle unless the output stalls or a read is pending
  assign q_take    = q_valid && !(ovalid_r && out_stall) && !rd_pend_r;
  assign out_valid = ovalid_r && !rd_pend_r;

  // read data from the memory lands in the cycle after the pop
  always_comb begin
    out_word = ow_r;
    if (ow_r.read_valid) out_word.read_data = rd_data_r;
  end

  assign tick_inc  = tick_r + 16'd1;
  assign retry_inc = retry_r + 17'd1;
  assign per       = (phase_r == PH_QUIET) ? quiet_ticks_r : echo_ticks_r;
  assign echo_zero = (echo_ticks_r == '0) || (echo_retries_r == '0);

  // item sequencer
  always_comb begin
    head_nxt = head_r; tail_nxt = tail_r; full_nxt = full_r; fill_nxt = fill_r;
    phase_nxt = phase_r; tick_nxt = tick_r; retry_nxt = retry_r;
    pend_nxt = pend_r; mism_nxt = mism_r; unseen_nxt = unseen_r;
    push = 1'b0; pop = 1'b0;
    ow_nxt = '0;
    case (q_word.kind)
      KIND_TICK: begin
        if (phase_r != PH_IDLE) begin
          tick_nxt = tick_inc;
          if (tick_inc >= per) begin
            tick_nxt  = '0;
            retry_nxt = retry_inc;
            if (phase_r == PH_QUIET) begin
              if (retry_inc > {1'b0, quiet_retries_r}) begin
                ow_nxt.status_valid = 1'b1;
                ow_nxt.status = full_r ? ST_FULL : ST_NEW;
                phase_nxt = PH_IDLE;
                unseen_nxt = 1'b0;
              end
            end else if (retry_inc >= {1'b0, echo_retries_r}) begin
              ow_nxt.status_valid = 1'b1;
              ow_nxt.status = mism_r ? ST_BAD_ECHO : ST_NO_ECHO;
              phase_nxt = PH_IDLE;
            end
          end
        end
      end
      KIND_RX: begin
        if (phase_r == PH_ECHO) begin
          if (full_r) begin
            ow_nxt.rx_refused = 1'b1;
            ow_nxt.status_valid = 1'b1;
            ow_nxt.status = ST_FULL_ECH;
            phase_nxt = PH_IDLE;
          end else if (q_word.data == pend_r) begin
            ow_nxt.status_valid = 1'b1;
            ow_nxt.status = mism_r ? ST_EXTRA : ST_OK;
            phase_nxt = PH_IDLE;
          end else begin
            push = 1'b1;
            mism_nxt = 1'b1;
            tick_nxt = '0; retry_nxt = '0;
            if (echo_zero) begin
              ow_nxt.status_valid = 1'b1;
              ow_nxt.status = ST_BAD_ECHO;
              phase_nxt = PH_IDLE;
            end
          end
        end else if (full_r) begin
          ow_nxt.rx_refused = 1'b1;
        end else begin
          push = 1'b1;
          if (phase_r == PH_QUIET) begin
            tick_nxt = '0; retry_nxt = '0;
          end else begin
            unseen_nxt = 1'b1;
          end
        end
      end
      default: begin
        if (phase_r != PH_IDLE) begin
          ow_nxt.status_valid = 1'b1;
          ow_nxt.status = ST_BUSY;
        end else if (q_word.kind == KIND_WRITE) begin
          if (unseen_r) begin
            unseen_nxt = 1'b0;
            phase_nxt = PH_QUIET;
            tick_nxt = '0; retry_nxt = '0;
            if (quiet_ticks_r == '0) begin
              ow_nxt.status_valid = 1'b1;
              ow_nxt.status = full_r ? ST_FULL : ST_NEW;
              phase_nxt = PH_IDLE;
            end
          end else if (full_r) begin
            ow_nxt.status_valid = 1'b1;
            ow_nxt.status = ST_FULL;
          end else begin
            ow_nxt.tx_valid = 1'b1;
            ow_nxt.tx_byte = q_word.data;
            pend_nxt = q_word.data;
            mism_nxt = 1'b0;
            phase_nxt = PH_ECHO;
            tick_nxt = '0; retry_nxt = '0;
            if (echo_zero) begin
              ow_nxt.status_valid = 1'b1;
              ow_nxt.status = ST_NO_ECHO;
              phase_nxt = PH_IDLE;
            end
          end
        end else begin
          unseen_nxt = 1'b0;
          if (fill_r != '0) begin
            pop = 1'b1;
            ow_nxt.read_valid = 1'b1;
          end
        end
      end
    endcase
    // pointer update
    if (push) begin
      tail_nxt = (tail_r == LAST) ? '0 : tail_r + AW'(1);
      fill_nxt = fill_r + FW'(1);
      full_nxt = (fill_r == FW'(RING_DEPTH - 1));
    end
    if (pop) begin
      head_nxt = (head_r == LAST) ? '0 : head_r + AW'(1);
      fill_nxt = fill_r - FW'(1);
      full_nxt = 1'b0;
    end
    ow_nxt.fill_count = 7'(fill_nxt);
    ow_nxt.ring_full  = full_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_ticks_r    <= CFG_W'(1);
      echo_retries_r  <= CFG_W'(3);
      quiet_ticks_r   <= CFG_W'(1);
      quiet_retries_r <= CFG_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ECHO_TICKS:   echo_ticks_r    <= cfg_data;
        REG_ECHO_RETRIES: echo_retries_r  <= cfg_data;
        REG_QUIET_TICKS:  quiet_ticks_r   <= cfg_data;
        REG_QUIET_RETRY:  quiet_retries_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0; tail_r <= '0; full_r <= 1'b0; fill_r <= '0;
      phase_r <= PH_IDLE; tick_r <= '0; retry_r <= '0;
      pend_r <= '0; mism_r <= 1'b0; unseen_r <= 1'b0;
      ovalid_r <= 1'b0; rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= q_take && pop;
      if (q_take) begin
        head_r <= head_nxt; tail_r <= tail_nxt; full_r <= full_nxt;
        fill_r <= fill_nxt; phase_r <= phase_nxt; tick_r <= tick_nxt;
        retry_r <= retry_nxt; pend_r <= pend_nxt; mism_r <= mism_nxt;
        unseen_r <= unseen_nxt;
        ovalid_r <= 1'b1;
      end else if (out_valid && !out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // output word and ring memory
  always_ff @(posedge clk) begin
    if (q_take) ow_r <= ow_nxt;
    if (q_take && push) mem[tail_r] <= q_word.data;
    if (q_take && pop) rd_data_r <= mem[head_r];
  end
endmodule
